@@ sv/ckg_pkg.sv @@
// Shared types, constants and sine table generation for the chaotic key byte generator.
`timescale 1ns / 1ps
`default_nettype none

package ckg_pkg;

  // Fraction and register widths
  localparam int unsigned FRAC_W    = 32;
  localparam int unsigned WARM_W    = 20;
  localparam int unsigned CFG_IDX_W = 8;
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned BIT_CNT_W = 3;

  // Sine table geometry: quarter wave, 2^B + 1 entries
  localparam int unsigned SINE_TABLE_BITS = 10;
  localparam int unsigned SINE_TAB_SIZE   = (1 << SINE_TABLE_BITS) + 1;
  localparam int unsigned SINE_IDX_W      = SINE_TABLE_BITS + 1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LOGISTIC_SEED = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_TENT_SEED     = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_SINE_SEED     = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_WARMUP_COUNT  = CFG_IDX_W'(3);

  // Register reset values
  localparam logic [FRAC_W-1:0] LOGISTIC_SEED_RST = 32'hAAAA_AAAA;
  localparam logic [FRAC_W-1:0] TENT_SEED_RST     = 32'h5555_5555;
  localparam logic [FRAC_W-1:0] SINE_SEED_RST     = 32'hCCCC_CCCC;
  localparam logic [WARM_W-1:0] WARMUP_RST        = WARM_W'(1000000);

  localparam logic [63:0] HALF_PI_Q62 = 64'h6487_ED51_10B4_611A;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WARM_MUL,
    ST_WARM_UPD,
    ST_BIT_MUL,
    ST_BIT_UPD,
    ST_DONE
  } state_e;

  // Sequencer commands to the map unit
  typedef struct packed {
    logic load;  // reload seeds
    logic warm;  // advance all three maps
    logic step;  // advance logistic, then tent or sine
  } map_ctl_t;

  // Configuration as held by the register file
  typedef struct packed {
    logic [FRAC_W-1:0] logistic_seed;
    logic [FRAC_W-1:0] tent_seed;
    logic [FRAC_W-1:0] sine_seed;
    logic [WARM_W-1:0] warmup_count;
  } cfg_t;

  typedef logic [FRAC_W-1:0] sine_tab_t [SINE_TAB_SIZE];

  // Bits [125:62] of the full 128-bit product
  function automatic logic [63:0] mul_q62(logic [63:0] a, logic [63:0] b);
    logic [127:0] p;
    p = {64'b0, a} * {64'b0, b};
    return p[125:62];
  endfunction

  // sin(pi/2 * i / 2^B) by Taylor series in Q2.62, rounded to Q0.32
  function automatic logic [FRAC_W-1:0] sine_entry(int unsigned i);
    logic [63:0] theta;
    logic [63:0] theta2;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] r;
    theta  = 64'((HALF_PI_Q62 >> 16) * 64'(i)) << (16 - SINE_TABLE_BITS);
    theta2 = mul_q62(theta, theta);
    term   = theta;
    sum    = theta;
    for (int unsigned k = 1; k <= 12; k++) begin
      term = mul_q62(term, theta2) / 64'((2 * k) * (2 * k + 1));
      if ((k & 1) != 0) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    r = (sum + (64'd1 << 29)) >> 30;
    if (r > 64'h0000_0000_FFFF_FFFF) begin
      return '1;
    end
    return r[FRAC_W-1:0];
  endfunction

  function automatic sine_tab_t build_sine_tab();
    sine_tab_t t;
    for (int unsigned i = 0; i < SINE_TAB_SIZE; i++) begin
      t[i] = sine_entry(i);
    end
    return t;
  endfunction

endpackage

`default_nettype wire

@@ sv/ckg_sine_rom.sv @@
// Quarter-wave sine ROM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module ckg_sine_rom (
  input  wire logic                            clk_i,
  input  wire logic [ckg_pkg::SINE_IDX_W-1:0]  addr_i,
  output logic      [ckg_pkg::FRAC_W-1:0]      data_o
);

  localparam ckg_pkg::sine_tab_t SineTab = ckg_pkg::build_sine_tab();

  logic [ckg_pkg::FRAC_W-1:0] data_q;

  // Synchronous read
  always_ff @(posedge clk_i) begin
    data_q <= SineTab[addr_i];
  end

  assign data_o = data_q;

endmodule

`default_nettype wire

@@ sv/ckg_map_unit.sv @@
// Shared map unit: holds the three map fractions and advances them on command.
`timescale 1ns / 1ps
`default_nettype none

module ckg_map_unit (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire ckg_pkg::map_ctl_t           ctl_i,
  input  wire ckg_pkg::cfg_t               cfg_i,
  output logic                             bit_o
);

  localparam int unsigned FW = ckg_pkg::FRAC_W;
  localparam int unsigned B  = ckg_pkg::SINE_TABLE_BITS;
  localparam int unsigned IW = ckg_pkg::SINE_IDX_W;
  localparam logic [IW-1:0] IdxMax = IW'(1) << B;

  logic [FW-1:0] logistic_q, logistic_d;
  logic [FW-1:0] tent_q, tent_d;
  logic [FW-1:0] sine_q, sine_d;

  // Registered logistic product x * (1 - x)
  logic [62:0]   prod_q;
  logic [FW:0]   compl;
  logic [64:0]   prod_full;

  assign compl     = {1'b1, {FW{1'b0}}} - {1'b0, logistic_q};
  assign prod_full = 65'(logistic_q) * 65'(compl);

  always_ff @(posedge clk_i) begin
    prod_q <= prod_full[62:0];
  end

  // Product >> 30, saturated at the largest fraction
  logic [FW:0]   logi_r;
  logic [FW-1:0] logi_next;

  assign logi_r    = prod_q[62:30];
  assign logi_next = logi_r[FW] ? '1 : logi_r[FW-1:0];

  // Tent map, 2x or 2(1 - x), saturated at exactly one half
  logic [FW:0]   tent_neg;
  logic [FW-1:0] tent_next;

  assign tent_neg = {1'b1, {FW{1'b0}}} - {1'b0, tent_q};

  always_comb begin
    if (!tent_q[FW-1]) begin
      tent_next = {tent_q[FW-2:0], 1'b0};
    end else if (tent_neg[FW-1]) begin
      tent_next = '1;
    end else begin
      tent_next = {tent_neg[FW-2:0], 1'b0};
    end
  end

  // Sine fold and rounded table index
  logic [FW:0]   sine_neg;
  logic [FW-1:0] fold;
  logic [FW-1:0] fold_rnd;
  logic [IW-1:0] idx_raw;
  logic [IW-1:0] idx;
  logic [FW-1:0] rom_data;

  assign sine_neg = {1'b1, {FW{1'b0}}} - {1'b0, sine_q};
  assign fold     = sine_q[FW-1] ? sine_neg[FW-1:0] : sine_q;
  assign fold_rnd = fold + (FW'(1) << (30 - B));
  assign idx_raw  = fold_rnd[31:31-B];
  assign idx      = (idx_raw > IdxMax) ? IdxMax : idx_raw;

  ckg_sine_rom u_rom (
    .clk_i  (clk_i),
    .addr_i (idx),
    .data_o (rom_data)
  );

  // Next fractions and output bit
  always_comb begin
    logistic_d = logistic_q;
    tent_d     = tent_q;
    sine_d     = sine_q;
    bit_o      = 1'b0;
    if (ctl_i.load) begin
      logistic_d = cfg_i.logistic_seed;
      tent_d     = cfg_i.tent_seed;
      sine_d     = cfg_i.sine_seed;
    end else if (ctl_i.warm) begin
      logistic_d = logi_next;
      tent_d     = tent_next;
      sine_d     = rom_data;
    end else if (ctl_i.step) begin
      logistic_d = logi_next;
      if (!logi_next[FW-1]) begin
        tent_d = tent_next;
        bit_o  = tent_next[FW-1];
      end else begin
        sine_d = rom_data;
        bit_o  = rom_data[FW-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      logistic_q <= '0;
      tent_q     <= '0;
      sine_q     <= '0;
    end else begin
      logistic_q <= logistic_d;
      tent_q     <= tent_d;
      sine_q     <= sine_d;
    end
  end

endmodule

`default_nettype wire

@@ sv/ckg_ctrl.sv @@
// Sequencer: restart handling, warmup and bit counters, byte assembly.
`timescale 1ns / 1ps
`default_nettype none

module ckg_ctrl (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  input  wire logic                           start_new_key_i,
  output logic                                in_ready_o,
  input  wire logic [ckg_pkg::WARM_W-1:0]     warmup_i,
  input  wire logic                           out_busy_i,
  input  wire logic                           map_bit_i,
  output ckg_pkg::map_ctl_t                   ctl_o,
  output logic                                out_load_o,
  output logic      [ckg_pkg::BYTE_W-1:0]     byte_o
);

  ckg_pkg::state_e state_q, state_d;

  logic [ckg_pkg::WARM_W-1:0]    warm_cnt_q, warm_cnt_d;
  logic [ckg_pkg::BIT_CNT_W-1:0] bit_cnt_q, bit_cnt_d;
  logic                          seeded_q, seeded_d;
  logic [ckg_pkg::BYTE_W-1:0]    byte_q, byte_d;

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    warm_cnt_d = warm_cnt_q;
    bit_cnt_d  = bit_cnt_q;
    seeded_d   = seeded_q;
    byte_d     = byte_q;
    ctl_o      = '0;
    in_ready_o = 1'b0;
    out_load_o = 1'b0;
    case (state_q)
      ckg_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          bit_cnt_d = '0;
          if (start_new_key_i || !seeded_q) begin
            ctl_o.load = 1'b1;
            seeded_d   = 1'b1;
            warm_cnt_d = warmup_i;
            state_d    = (warmup_i == '0) ? ckg_pkg::ST_BIT_MUL : ckg_pkg::ST_WARM_MUL;
          end else begin
            state_d = ckg_pkg::ST_BIT_MUL;
          end
        end
      end
      ckg_pkg::ST_WARM_MUL: begin
        state_d = ckg_pkg::ST_WARM_UPD;
      end
      ckg_pkg::ST_WARM_UPD: begin
        ctl_o.warm = 1'b1;
        warm_cnt_d = warm_cnt_q - ckg_pkg::WARM_W'(1);
        state_d    = (warm_cnt_q == ckg_pkg::WARM_W'(1)) ? ckg_pkg::ST_BIT_MUL
                                                         : ckg_pkg::ST_WARM_MUL;
      end
      ckg_pkg::ST_BIT_MUL: begin
        state_d = ckg_pkg::ST_BIT_UPD;
      end
      ckg_pkg::ST_BIT_UPD: begin
        ctl_o.step = 1'b1;
        byte_d     = {byte_q[ckg_pkg::BYTE_W-2:0], map_bit_i};
        bit_cnt_d  = bit_cnt_q + ckg_pkg::BIT_CNT_W'(1);
        state_d    = (bit_cnt_q == '1) ? ckg_pkg::ST_DONE : ckg_pkg::ST_BIT_MUL;
      end
      ckg_pkg::ST_DONE: begin
        // hand over once the output register is free
        if (!out_busy_i) begin
          out_load_o = 1'b1;
          state_d    = ckg_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = ckg_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ckg_pkg::ST_IDLE;
      warm_cnt_q <= '0;
      bit_cnt_q  <= '0;
      seeded_q   <= 1'b0;
    end else begin
      state_q    <= state_d;
      warm_cnt_q <= warm_cnt_d;
      bit_cnt_q  <= bit_cnt_d;
      seeded_q   <= seeded_d;
    end
  end

  // Byte shift register
  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
  end

  assign byte_o = byte_q;

endmodule

`default_nettype wire

@@ sv/chaotic_map_key_byte_generator.sv @@
// Top level of the chaotic map key byte generator.
// Each transfer on the input channel (in_valid_i / in_ready_o) requests one
// key byte; start_new_key_i set reloads the three seeds and runs the warmup
// first. The first request after reset always restarts. The byte leaves on
// the output channel (out_valid_o / out_ready_i), first generated bit in
// bit 7. Registers are written over the cfg channel (always ready); the user
// must write them only while the block is idle, which the block itself does
// not enforce. Seeds and warmup count take effect at a restart. Each map
// iteration has a multiply state, for the logistic multiplier and the sine
// ROM read, and an update state. A byte takes one iteration per bit, and a
// restart first adds warmup_count iterations. One item is in work at a time;
// in_ready_o is high only while the sequencer idles.
// The output register holds a finished byte while the receiver stalls and a
// new request is taken meanwhile; its byte waits until the register is free.
// Reset clears the maps, the seeded flag and the output valid, and returns
// the registers to their reset values.
`timescale 1ns / 1ps
`default_nettype none

module chaotic_map_key_byte_generator (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_ready_o,
  input  wire logic                              start_new_key_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output logic      [ckg_pkg::BYTE_W-1:0]        key_byte_o,
  input  wire logic                              cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire logic [ckg_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  wire logic [ckg_pkg::FRAC_W-1:0]        cfg_data_i
);

  ckg_pkg::cfg_t     cfg_q;
  ckg_pkg::map_ctl_t map_ctl;
  logic              map_bit;
  logic              out_load;
  logic              out_busy;
  logic [ckg_pkg::BYTE_W-1:0] gen_byte;
  logic              out_valid_q;
  logic [ckg_pkg::BYTE_W-1:0] key_byte_q;

  assign cfg_ready_o = 1'b1;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.logistic_seed <= ckg_pkg::LOGISTIC_SEED_RST;
      cfg_q.tent_seed     <= ckg_pkg::TENT_SEED_RST;
      cfg_q.sine_seed     <= ckg_pkg::SINE_SEED_RST;
      cfg_q.warmup_count  <= ckg_pkg::WARMUP_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        ckg_pkg::CFG_LOGISTIC_SEED: cfg_q.logistic_seed <= cfg_data_i;
        ckg_pkg::CFG_TENT_SEED:     cfg_q.tent_seed     <= cfg_data_i;
        ckg_pkg::CFG_SINE_SEED:     cfg_q.sine_seed     <= cfg_data_i;
        ckg_pkg::CFG_WARMUP_COUNT:  cfg_q.warmup_count  <= cfg_data_i[ckg_pkg::WARM_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign out_busy = out_valid_q && !out_ready_i;

  ckg_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .start_new_key_i (start_new_key_i),
    .in_ready_o      (in_ready_o),
    .warmup_i        (cfg_q.warmup_count),
    .out_busy_i      (out_busy),
    .map_bit_i       (map_bit),
    .ctl_o           (map_ctl),
    .out_load_o      (out_load),
    .byte_o          (gen_byte)
  );

  ckg_map_unit u_map (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (map_ctl),
    .cfg_i  (cfg_q),
    .bit_o  (map_bit)
  );

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      key_byte_q <= gen_byte;
    end
  end

  assign out_valid_o = out_valid_q;
  assign key_byte_o  = key_byte_q;

endmodule

`default_nettype wire

@@ test/tb_chaotic_map_key_byte_generator.sv @@
// Self-checking testbench for the chaotic map key byte generator.
`timescale 1ns / 1ps

module tb_chaotic_map_key_byte_generator;

  localparam int unsigned TAB_BITS      = ckg_pkg::SINE_TABLE_BITS;
  localparam int unsigned ROM_DEPTH     = (1 << TAB_BITS) + 1;
  localparam logic [63:0] QUARTER_TURN  = 64'h6487_ED51_10B4_611A; // pi/2 in Q2.62
  localparam logic [31:0] HALF_Q32      = 32'h8000_0000;
  localparam int          RAND_ITEMS    = 1900;
  localparam int          SETTLE_CYCLES = 20;
  localparam int          DRAIN_CYCLES  = 40;
  localparam int          HOLD_CYCLES   = 300;
  localparam int          IDLE_LIMIT    = 20000;
  localparam int          MAX_REPORTS   = 10;

  // Indexes that hit no register
  localparam logic [ckg_pkg::CFG_IDX_W-1:0] CFG_SPARE_IDX = ckg_pkg::CFG_IDX_W'(4);
  localparam logic [ckg_pkg::CFG_IDX_W-1:0] CFG_TOP_IDX   = '1;

  // Seeds that sit on fixed points, the half point and the range ends
  localparam logic [31:0] EDGE_SEEDS [7] = '{
    32'h0000_0000, 32'h0000_0001, 32'h7FFF_FFFF, 32'h8000_0000,
    32'hBFFF_FFFF, 32'hC000_0000, 32'hFFFF_FFFF
  };

  // Directed row: registers to write (bit per index), then one request
  typedef struct packed {
    logic [3:0]  wr_mask;
    logic        spare_wr;
    logic [31:0] seed_l;
    logic [31:0] seed_t;
    logic [31:0] seed_s;
    logic [31:0] warm;
    logic        restart;
    logic        known;
    logic [7:0]  key;
  } dir_row_t;

  localparam int DIR_ROWS = 18;
  localparam dir_row_t DIR_TAB [DIR_ROWS] = '{
    // first request restarts on its own; warmup data bits above 20 dropped
    '{4'b1000, 1'b0, 32'h0, 32'h0, 32'h0, 32'hFFF0_0000, 1'b0, 1'b0, 8'h00},
    '{4'b0000, 1'b0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0, 1'b0, 8'h00},
    '{4'b0000, 1'b0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b1, 1'b0, 8'h00},
    // all maps stuck at zero
    '{4'b1111, 1'b0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b1, 1'b1, 8'h00},
    // tent from one half saturates, then falls to two and doubles from there
    '{4'b1111, 1'b0, 32'h0, 32'h8000_0000, 32'h0, 32'h0, 1'b1, 1'b1, 8'h80},
    // logistic held at three quarters, sine from one half peaks then dies
    '{4'b1111, 1'b0, 32'hC000_0000, 32'h0, 32'h8000_0000, 32'h0, 1'b1, 1'b1, 8'h80},
    // logistic from exact half saturates, then tent saturates once
    '{4'b1111, 1'b0, 32'h8000_0000, 32'h8000_0000, 32'h0, 32'h0, 1'b1, 1'b1, 8'h40},
    '{4'b1111, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 1'b1, 1'b0, 8'h00},
    '{4'b1111, 1'b0, 32'h1, 32'h1, 32'h1, 32'h1, 1'b1, 1'b0, 8'h00},
    '{4'b0000, 1'b0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0, 1'b0, 8'h00},
    // new seeds must wait for the next restart
    '{4'b0111, 1'b0, 32'h1234_5678, 32'h9ABC_DEF0, 32'h0F0F_0F0F, 32'h0, 1'b0, 1'b0, 8'h00},
    '{4'b0000, 1'b0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b1, 1'b0, 8'h00},
    // writes to unused indexes change nothing
    '{4'b0000, 1'b1, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0, 1'b0, 8'h00},
    '{4'b1000, 1'b0, 32'h0, 32'h0, 32'h0, 32'hABC0_03E8, 1'b1, 1'b0, 8'h00},
    '{4'b0000, 1'b0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0, 1'b0, 8'h00},
    '{4'b1111, 1'b0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0, 1'b1, 1'b0, 8'h00},
    // sine stuck at zero under a fixed logistic
    '{4'b1111, 1'b0, 32'hC000_0000, 32'h0, 32'h0, 32'h0, 1'b1, 1'b1, 8'h00},
    '{4'b0000, 1'b0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0, 1'b1, 8'h00}
  };

  logic                          clk_i;
  logic                          rst_ni;
  logic                          in_valid_i;
  logic                          in_ready_o;
  logic                          start_new_key_i;
  logic                          out_valid_o;
  logic                          out_ready_i;
  logic [ckg_pkg::BYTE_W-1:0]    key_byte_o;
  logic                          cfg_valid_i;
  logic                          cfg_ready_o;
  logic [ckg_pkg::CFG_IDX_W-1:0] cfg_index_i;
  logic [ckg_pkg::FRAC_W-1:0]    cfg_data_i;

  // Hand-computed byte travelling with a request, if any
  logic        known_key_en;
  logic [7:0]  known_key;

  // Predictor state and register copy
  logic [31:0]   sin_rom [ROM_DEPTH];
  logic [31:0]   lmap;
  logic [31:0]   tmap;
  logic [31:0]   smap;
  logic          seeded;
  ckg_pkg::cfg_t reg_copy;

  logic [7:0]  expected_key_q [$];
  int          mismatch_cnt;
  int          idle_cnt;
  int          send_run;

  chaotic_map_key_byte_generator i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .start_new_key_i (start_new_key_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .key_byte_o      (key_byte_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Q2.62 product, kept to 64 bits
  function automatic logic [63:0] q62_mul(logic [63:0] a, logic [63:0] b);
    logic [127:0] full;
    full = {64'd0, a} * {64'd0, b};
    return 64'(full >> 62);
  endfunction

  // Quarter-wave sine entry: Taylor series in Q2.62, rounded to Q0.32
  function automatic logic [31:0] sine_q32(int unsigned idx);
    logic [63:0] ang;
    logic [63:0] ang2;
    logic [63:0] term;
    logic [63:0] acc;
    logic [63:0] rnd;
    ang  = (64'(QUARTER_TURN >> 16) * 64'(idx)) << (16 - TAB_BITS);
    ang2 = q62_mul(ang, ang);
    term = ang;
    acc  = ang;
    for (int unsigned k = 1; k <= 12; k++) begin
      term = q62_mul(term, ang2) / 64'((2 * k) * (2 * k + 1));
      if (k % 2 == 1) begin
        acc = acc - term;
      end else begin
        acc = acc + term;
      end
    end
    rnd = (acc + (64'd1 << 29)) >> 30;
    return (rnd > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : rnd[31:0];
  endfunction

  function automatic logic [31:0] logistic_next(logic [31:0] x);
    logic [63:0] prod;
    prod = (64'(x) * (64'h1_0000_0000 - 64'(x))) >> 30;
    return (prod > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : prod[31:0];
  endfunction

  function automatic logic [31:0] tent_next(logic [31:0] x);
    logic [63:0] dbl;
    if (x < HALF_Q32) begin
      dbl = 64'(x) << 1;
    end else begin
      dbl = (64'h1_0000_0000 - 64'(x)) << 1;
    end
    return (dbl > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : dbl[31:0];
  endfunction

  function automatic logic [31:0] sine_next(logic [31:0] x);
    logic [63:0] fold;
    logic [63:0] idx;
    fold = (x < HALF_Q32) ? 64'(x) : 64'h1_0000_0000 - 64'(x);
    idx  = (fold + (64'd1 << (30 - TAB_BITS))) >> (31 - TAB_BITS);
    if (idx >= 64'(ROM_DEPTH)) begin
      idx = 64'(ROM_DEPTH - 1);
    end
    return sin_rom[idx[TAB_BITS:0]];
  endfunction

  // Byte for one request; restarts on demand or when never seeded
  function automatic logic [7:0] next_key_byte(logic restart);
    logic [7:0]  acc;
    logic [31:0] v;
    if (restart || !seeded) begin
      lmap = reg_copy.logistic_seed;
      tmap = reg_copy.tent_seed;
      smap = reg_copy.sine_seed;
      for (int unsigned n = 0; n < reg_copy.warmup_count; n++) begin
        lmap = logistic_next(lmap);
        tmap = tent_next(tmap);
        smap = sine_next(smap);
      end
      seeded = 1'b1;
    end
    acc = '0;
    for (int j = 0; j < ckg_pkg::BYTE_W; j++) begin
      lmap = logistic_next(lmap);
      if (lmap < HALF_Q32) begin
        tmap = tent_next(tmap);
        v    = tmap;
      end else begin
        smap = sine_next(smap);
        v    = smap;
      end
      acc = {acc[6:0], v >= HALF_Q32};
    end
    return acc;
  endfunction

  function automatic void flag_mismatch(string what);
    mismatch_cnt++;
    if (mismatch_cnt <= MAX_REPORTS) begin
      $display("[%0t] mismatch: %s", $realtime, what);
    end
  endfunction

  // Wait length for one item; now and then a run of back-to-back items
  function automatic int draw_wait(inout int run_left);
    if (run_left > 0) begin
      run_left--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) begin
      run_left = $urandom_range(10, 30);
      return 0;
    end
    return $urandom_range(0, 9);
  endfunction

  function automatic logic [31:0] pick_seed();
    if ($urandom_range(0, 3) == 0) begin
      return EDGE_SEEDS[$urandom_range(0, 6)];
    end
    return $urandom;
  endfunction

  // Monitor: register copy, prediction on request, check on key byte
  always @(posedge clk_i or negedge rst_ni) begin : monitor
    logic [7:0] pred;
    logic [7:0] want;
    if (!rst_ni) begin
      lmap     = '0;
      tmap     = '0;
      smap     = '0;
      seeded   = 1'b0;
      reg_copy = '{ckg_pkg::LOGISTIC_SEED_RST, ckg_pkg::TENT_SEED_RST,
                   ckg_pkg::SINE_SEED_RST, ckg_pkg::WARMUP_RST};
      idle_cnt <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          ckg_pkg::CFG_LOGISTIC_SEED: reg_copy.logistic_seed = cfg_data_i;
          ckg_pkg::CFG_TENT_SEED:     reg_copy.tent_seed     = cfg_data_i;
          ckg_pkg::CFG_SINE_SEED:     reg_copy.sine_seed     = cfg_data_i;
          ckg_pkg::CFG_WARMUP_COUNT:
            reg_copy.warmup_count = cfg_data_i[ckg_pkg::WARM_W-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_o) begin
        pred = next_key_byte(start_new_key_i);
        expected_key_q.push_back(known_key_en ? known_key : pred);
      end
      if (out_valid_o && out_ready_i) begin
        if (expected_key_q.size() == 0) begin
          flag_mismatch($sformatf("key byte %02h with none expected", key_byte_o));
        end else begin
          want = expected_key_q.pop_front();
          if (key_byte_o !== want) begin
            flag_mismatch($sformatf("key_byte expected %02h, got %02h", want, key_byte_o));
          end
        end
      end
      if ((cfg_valid_i && cfg_ready_o) || (in_valid_i && in_ready_o) ||
          (out_valid_o && out_ready_i)) begin
        idle_cnt <= 0;
      end else begin
        idle_cnt <= idle_cnt + 1;
      end
    end
  end

  // Watchdog on cycles without any transfer
  initial begin : watchdog
    @(posedge rst_ni);
    while (idle_cnt < IDLE_LIMIT) @(posedge clk_i);
    $display("** chaotic_map_key_byte_generator: FAILED **");
    $finish;
  end

  // Receiver: random stalls, twice a long hold-off while requests queue up
  initial begin : receiver
    int run_left;
    int taken;
    int hold_at;
    int stall;
    out_ready_i = 1'b0;
    run_left    = 0;
    taken       = 0;
    hold_at     = 150;
    @(posedge rst_ni);
    forever begin
      stall = draw_wait(run_left);
      @(negedge clk_i);
      if (taken >= hold_at && in_valid_i) begin
        stall   = HOLD_CYCLES;
        hold_at = taken + 900;
      end
      if (stall != 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      taken++;
    end
  end

  // One request transfer after a random gap
  task automatic send_item(logic restart, logic known, logic [7:0] key);
    int gap;
    gap = draw_wait(send_run);
    @(negedge clk_i);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i      <= 1'b1;
    start_new_key_i <= restart;
    known_key_en    <= known;
    known_key       <= key;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic write_reg(logic [ckg_pkg::CFG_IDX_W-1:0] idx, logic [31:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  task automatic park_sender();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  // Register writes once the block has drained
  task automatic configure(logic [3:0] mask, logic spare, logic [31:0] sl,
                           logic [31:0] st, logic [31:0] ss, logic [31:0] wu);
    park_sender();
    while (expected_key_q.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    if (mask[ckg_pkg::CFG_LOGISTIC_SEED]) write_reg(ckg_pkg::CFG_LOGISTIC_SEED, sl);
    if (mask[ckg_pkg::CFG_TENT_SEED])     write_reg(ckg_pkg::CFG_TENT_SEED, st);
    if (mask[ckg_pkg::CFG_SINE_SEED])     write_reg(ckg_pkg::CFG_SINE_SEED, ss);
    if (mask[ckg_pkg::CFG_WARMUP_COUNT])  write_reg(ckg_pkg::CFG_WARMUP_COUNT, wu);
    if (spare) begin
      write_reg(CFG_SPARE_IDX, $urandom);
      write_reg(CFG_TOP_IDX, $urandom);
    end
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Main sequence
  initial begin : stimulus
    int          rand_sent;
    int          burst;
    logic [3:0]  mask;
    logic [31:0] warm;
    rst_ni          = 1'b0;
    in_valid_i      = 1'b0;
    start_new_key_i = 1'b0;
    known_key_en    = 1'b0;
    known_key       = '0;
    cfg_valid_i     = 1'b0;
    cfg_index_i     = '0;
    cfg_data_i      = '0;
    mismatch_cnt    = 0;
    send_run        = 0;
    rand_sent       = 0;
    for (int unsigned i = 0; i < ROM_DEPTH; i++) begin
      sin_rom[i] = sine_q32(i);
    end
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed rows
    for (int r = 0; r < DIR_ROWS; r++) begin
      if (DIR_TAB[r].wr_mask != '0 || DIR_TAB[r].spare_wr) begin
        configure(DIR_TAB[r].wr_mask, DIR_TAB[r].spare_wr, DIR_TAB[r].seed_l,
                  DIR_TAB[r].seed_t, DIR_TAB[r].seed_s, DIR_TAB[r].warm);
      end
      send_item(DIR_TAB[r].restart, DIR_TAB[r].known, DIR_TAB[r].key);
    end

    // Random phases: new registers, then a burst of requests
    while (rand_sent < RAND_ITEMS) begin
      mask = ($urandom_range(0, 9) < 7) ? 4'b1111 : 4'($urandom_range(1, 15));
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: warm = $urandom_range(0, 32);
        6, 7:             warm = '0;
        8:                warm = $urandom_range(33, 400);
        default:          warm = ($urandom & 32'hFFF0_0000) | $urandom_range(0, 16);
      endcase
      configure(mask, $urandom_range(0, 7) == 0, pick_seed(), pick_seed(), pick_seed(),
                warm);
      burst = $urandom_range(20, 60);
      repeat (burst) begin
        send_item($urandom_range(0, 3) == 0, 1'b0, 8'h00);
        rand_sent++;
      end
    end

    // Drain and verdict
    park_sender();
    while (expected_key_q.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (expected_key_q.size() != 0) begin
      flag_mismatch($sformatf("%0d key bytes never arrived", expected_key_q.size()));
    end
    if (mismatch_cnt == 0) begin
      $display("** chaotic_map_key_byte_generator: PASSED **");
    end else begin
      $display("** chaotic_map_key_byte_generator: FAILED **");
    end
    $finish;
  end

endmodule

@@ sim.f @@
sv/ckg_pkg.sv
sv/ckg_sine_rom.sv
sv/ckg_map_unit.sv
sv/ckg_ctrl.sv
sv/chaotic_map_key_byte_generator.sv
test/tb_chaotic_map_key_byte_generator.sv
